### hw/rtl/rgb_alpha_blend_to_yuv420_macros.svh
// Assertion macros shared by the RTL. Each macro checks an implication on
// the rising edge of the given clock and is disabled while reset is high.
`ifndef RGB_ALPHA_BLEND_TO_YUV420_MACROS_SVH
`define RGB_ALPHA_BLEND_TO_YUV420_MACROS_SVH

`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define RAB_ASSERT_SAME(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("rab assertion failed: same-cycle implication");
// Consequent holds in the cycle after the antecedent.
`define RAB_ASSERT_NEXT(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("rab assertion failed: next-cycle implication");
`else
`define RAB_ASSERT_SAME(label, c, r, ante, cons)
`define RAB_ASSERT_NEXT(label, c, r, ante, cons)
`endif

`endif

### hw/rtl/rab_pkg.sv
// ----------------------------------------------------------------------------
// rab_pkg
// Types, register codes and conversion constants of the blend and YUV block.
// ----------------------------------------------------------------------------
`default_nettype none

package rab_pkg;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int LINE_W      = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLEND_ALPHA = 2'd0,
    REG_BLEND_MODE  = 2'd1,
    REG_LINE_WIDTH  = 2'd2
  } rab_reg_t;

  localparam logic [7:0]        ALPHA_RESET = 8'd128;
  localparam logic              MODE_RESET  = 1'b1;
  localparam logic [LINE_W-1:0] WIDTH_RESET = 13'd1920;

  localparam logic MODE_SCALE = 1'b0;
  localparam logic MODE_BLEND = 1'b1;

  // BT.601 studio-range coefficients, scaled by 256.
  localparam logic [7:0] K_Y_R = 8'd66;
  localparam logic [7:0] K_Y_G = 8'd129;
  localparam logic [7:0] K_Y_B = 8'd25;
  localparam logic [7:0] K_U_R = 8'd38;
  localparam logic [7:0] K_U_G = 8'd74;
  localparam logic [7:0] K_U_B = 8'd112;
  localparam logic [7:0] K_V_R = 8'd112;
  localparam logic [7:0] K_V_G = 8'd94;
  localparam logic [7:0] K_V_B = 8'd18;
  localparam logic [7:0] Y_OFFSET = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic blend;
    logic load;
  } rab_cmd_t;

  // floor(v * k / 256) for unsigned operands.
  function automatic logic [7:0] scale_term(input logic [7:0] v, input logic [7:0] k);
    logic [15:0] p;
    p = 16'(v) * 16'(k);
    return p[15:8];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rab_channels.sv
// ----------------------------------------------------------------------------
// rab_channels
// Pixel input and YUV output channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_red;
  logic [7:0] first_green;
  logic [7:0] first_blue;
  logic [7:0] second_red;
  logic [7:0] second_green;
  logic [7:0] second_blue;
  logic       frame_start;

  modport source (
    output valid, first_red, first_green, first_blue,
           second_red, second_green, second_blue, frame_start,
    input  ready
  );
  modport sink (
    input  valid, first_red, first_green, first_blue,
           second_red, second_green, second_blue, frame_start,
    output ready
  );
endinterface

interface rab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (
    output valid, luma, chroma_valid, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma, chroma_valid, chroma_blue, chroma_red,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/rab_ctrl.sv
// ----------------------------------------------------------------------------
// rab_ctrl
// Sequencer: accept a word, blend it, convert it, hand it to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rab_ctrl
  import rab_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output rab_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLEND,
    ST_CONV
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.blend   = (state == ST_BLEND);
    cmd.load    = (state == ST_CONV) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result takes the output register in the same edge that the
      // previous one leaves it.
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          state <= ST_CONV;
        end
        ST_CONV: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rab_datapath.sv
// ----------------------------------------------------------------------------
// rab_datapath
// Configuration registers, position counters, blend and YUV conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module rab_datapath
  import rab_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire rab_cmd_t               cmd,
  input  wire logic [7:0]             first_red,
  input  wire logic [7:0]             first_green,
  input  wire logic [7:0]             first_blue,
  input  wire logic [7:0]             second_red,
  input  wire logic [7:0]             second_green,
  input  wire logic [7:0]             second_blue,
  input  wire logic                   frame_start,
  output logic [7:0]                  luma,
  output logic                        chroma_valid,
  output logic [7:0]                  chroma_blue,
  output logic [7:0]                  chroma_red
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (LINE_W > CW + 1) ? LINE_W : CW + 1;
  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_WIDTH);

  logic [7:0]        blend_alpha;
  logic              blend_mode;
  logic [LINE_W-1:0] line_width;

  logic [CW-1:0] column_count;
  logic          row_odd;

  logic [7:0] c1 [3];
  logic [7:0] c2 [3];
  logic [7:0] mix [3];
  logic       chroma_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_alpha <= ALPHA_RESET;
      blend_mode  <= MODE_RESET;
      line_width  <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_ALPHA: blend_alpha <= cfg_data[7:0];
        REG_BLEND_MODE:  blend_mode  <= cfg_data[0];
        REG_LINE_WIDTH:  line_width  <= cfg_data[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Position of the pixel being captured; a frame start forces the origin.
  logic [CW-1:0]   col_cur;
  logic            odd_cur;
  logic [CMPW-1:0] width_eff;
  logic [CMPW-1:0] col_inc;
  logic            row_end;

  always_comb begin
    col_cur   = frame_start ? '0 : column_count;
    odd_cur   = frame_start ? 1'b0 : row_odd;
    width_eff = (CMPW'(line_width) > MAX_W) ? MAX_W : CMPW'(line_width);
    col_inc   = CMPW'(col_cur) + CMPW'(1);
    row_end   = (col_inc >= width_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_odd      <= 1'b0;
    end else if (cmd.capture) begin
      column_count <= row_end ? '0 : col_inc[CW-1:0];
      row_odd      <= row_end ? !odd_cur : odd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c1[0]       <= first_red;
      c1[1]       <= first_green;
      c1[2]       <= first_blue;
      c2[0]       <= second_red;
      c2[1]       <= second_green;
      c2[2]       <= second_blue;
      chroma_hold <= !odd_cur && !col_cur[0];
    end
  end

  // Scale mode is the blend with a black second image.
  logic [7:0]         base [3];
  logic signed [8:0]  diff [3];
  logic signed [17:0] prod [3];
  logic signed [17:0] frac [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      base[k] = (blend_mode == MODE_BLEND) ? c2[k] : 8'd0;
      diff[k] = $signed({1'b0, c1[k]}) - $signed({1'b0, base[k]});
      prod[k] = 18'(diff[k]) * $signed({10'd0, blend_alpha});
      frac[k] = prod[k] >>> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      for (int k = 0; k < 3; k++) begin
        mix[k] <= base[k] + frac[k][7:0];
      end
    end
  end

  // Results stay inside 0..255 for all 8-bit inputs, so 8-bit sums suffice.
  logic [7:0] y_sum;
  logic [7:0] u_sum;
  logic [7:0] v_sum;

  always_comb begin
    y_sum = scale_term(mix[0], K_Y_R) + scale_term(mix[1], K_Y_G)
          + scale_term(mix[2], K_Y_B) + Y_OFFSET;
    u_sum = C_OFFSET + scale_term(mix[2], K_U_B)
          - scale_term(mix[0], K_U_R) - scale_term(mix[1], K_U_G);
    v_sum = C_OFFSET + scale_term(mix[0], K_V_R)
          - scale_term(mix[1], K_V_G) - scale_term(mix[2], K_V_B);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      luma         <= y_sum;
      chroma_valid <= chroma_hold;
      chroma_blue  <= chroma_hold ? u_sum : 8'd0;
      chroma_red   <= chroma_hold ? v_sum : 8'd0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rgb_alpha_blend_to_yuv420.sv
// ----------------------------------------------------------------------------
// rgb_alpha_blend_to_yuv420
// Alpha blend of two RGB pixels, then BT.601 studio-range YUV with 4:2:0 chroma.
// ----------------------------------------------------------------------------
// Each input word carries one pixel position from two images. The block mixes
// them with the configured alpha (or scales the first image alone), converts
// the result to studio-range Y, U and V, and returns one output word per
// input word in order. Chroma is flagged valid on even rows and even columns;
// elsewhere U and V read as zero. The controller captures a pixel, blends it
// in the three alpha multipliers and then runs the constant-coefficient
// conversion into the output register once that is free; no new pixel is
// taken before that load. The output register holds a finished word, so the
// next pixel is accepted while it waits. There is no clearing pass after
// reset; the block accepts a word in the first cycle after reset is released.
// Configuration must be written only while idle; the block does not check it.
`default_nettype none

`include "rgb_alpha_blend_to_yuv420_macros.svh"

module rgb_alpha_blend_to_yuv420
  import rab_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  rab_in_if.sink                      pix_in,
  rab_out_if.source                   pix_out
);

  rab_cmd_t cmd;

  // The controller owns the handshake on both channels; the datapath only
  // sees the commands it issues.
  rab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .cmd       (cmd)
  );

  // The datapath keeps the registers, the column and row-parity counters,
  // and the output payload register.
  rab_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .first_red    (pix_in.first_red),
    .first_green  (pix_in.first_green),
    .first_blue   (pix_in.first_blue),
    .second_red   (pix_in.second_red),
    .second_green (pix_in.second_green),
    .second_blue  (pix_in.second_blue),
    .frame_start  (pix_in.frame_start),
    .luma         (pix_out.luma),
    .chroma_valid (pix_out.chroma_valid),
    .chroma_blue  (pix_out.chroma_blue),
    .chroma_red   (pix_out.chroma_red)
  );

  // After a word is taken the block is busy with it.
  `RAB_ASSERT_NEXT(a_busy_after_accept, clk, rst, pix_in.valid && pix_in.ready, !pix_in.ready)
  // A result is never loaded over one that is still waiting.
  `RAB_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.load, !pix_out.valid || pix_out.ready)
  // Off the chroma grid, U and V are driven as zero.
  `RAB_ASSERT_SAME(a_chroma_zero, clk, rst, pix_out.valid && !pix_out.chroma_valid, pix_out.chroma_blue == 8'd0 && pix_out.chroma_red == 8'd0)
  // A loaded result is offered in the next cycle.
  `RAB_ASSERT_NEXT(a_load_offers, clk, rst, cmd.load, pix_out.valid)

endmodule

`default_nettype wire

### tb/sv/rgb_alpha_blend_to_yuv420_tb.sv
// ----------------------------------------------------------------------------
// rgb_alpha_blend_to_yuv420_tb
// Self-checking testbench for the alpha blend and BT.601 YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
// Pixel pairs are queued by the test sequence and offered by a clocked driver.
// Every word the block accepts is run through a local model of the blend, the
// color conversion and the row/column position tracking, and the result is
// queued. A clocked monitor pops the oldest expected word for every output
// word and compares it field by field. Both sides may insert random idle cycles.
// ----------------------------------------------------------------------------
module rgb_alpha_blend_to_yuv420_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rab_pkg::*;

  // Position counters of the block wrap at this many pixels per row.
  localparam int LINE_MAX = 4096;
  // Cycles without any handshake or register write before the run is abandoned.
  // The longest legal quiet stretch is the deliberate output hold-off below.
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  // A pixel passes the capture, blend and convert states, plus the output register.
  localparam int SETTLE_CYCLES = 6;

  typedef struct {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic       frame_start;
  } rgb_pair_t;

  typedef struct {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuv_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_BLEND_ALPHA;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  rab_in_if  pix_in_if ();
  rab_out_if pix_out_if ();

  rgb_alpha_blend_to_yuv420 #(
    .MAX_WIDTH(LINE_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_if),
    .pix_out  (pix_out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the block's settings and position state.
  // --------------------------------------------------------------------------
  logic [7:0]        alpha_setting = ALPHA_RESET;
  logic              mode_setting  = MODE_RESET;
  logic [LINE_W-1:0] width_setting = WIDTH_RESET;
  logic [11:0]       column_pos    = '0;
  logic              row_is_odd    = 1'b0;

  rgb_pair_t pixel_q[$];        // pixels waiting for the driver
  yuv_word_t yuv_expect_q[$];   // predicted output words, oldest first

  rgb_pair_t pixel_on_offer;
  bit        offer_pending = 1'b0;
  bit        sender_idle   = 1'b1;
  bit        receiver_idle = 1'b1;
  bit        hold_request  = 1'b0;
  int        send_gap      = 0;
  int        hold_left     = 0;
  int        idle_cycles   = 0;
  int        error_count   = 0;
  int        words_checked = 0;
  int        chroma_words  = 0;
  int        setting_count = 0;

  // Register writes take effect at the edge where the enable is seen high.
  always @(posedge clk) begin
    if (!rst && cfg_we) begin
      case (cfg_index)
        REG_BLEND_ALPHA: alpha_setting = cfg_data[7:0];
        REG_BLEND_MODE:  mode_setting = cfg_data[0];
        REG_LINE_WIDTH:  width_setting = cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // One color component after the alpha stage. The arithmetic shift of the
  // signed product gives the floor, also for a negative difference.
  function automatic int mix_channel(logic [7:0] c1, logic [7:0] c2);
    int a1;
    int a2;
    int weight;
    a1 = c1;
    a2 = c2;
    weight = alpha_setting;
    if (mode_setting == MODE_SCALE) return (a1 * weight) >>> 8;
    return a2 + (((a1 - a2) * weight) >>> 8);
  endfunction

  // Truncated product of one color term.
  function automatic int coef_term(int level, int coef);
    return (level * coef) >>> 8;
  endfunction

  function automatic logic [7:0] clip_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // Expected output word for one accepted pixel; advances the position state.
  function automatic yuv_word_t convert_pixel(rgb_pair_t px);
    yuv_word_t w;
    int        r;
    int        g;
    int        b;
    int        y_sum;
    int        u_sum;
    int        v_sum;
    int        y_base;
    int        c_base;
    int        span;
    logic      on_chroma;
    if (px.frame_start) begin
      column_pos = '0;
      row_is_odd = 1'b0;
    end
    r = mix_channel(px.first_red, px.second_red);
    g = mix_channel(px.first_green, px.second_green);
    b = mix_channel(px.first_blue, px.second_blue);
    y_base = Y_OFFSET;
    c_base = C_OFFSET;
    y_sum = coef_term(r, K_Y_R) + coef_term(g, K_Y_G) + coef_term(b, K_Y_B) + y_base;
    u_sum = c_base + coef_term(b, K_U_B) - (coef_term(r, K_U_R) + coef_term(g, K_U_G));
    v_sum = c_base + coef_term(r, K_V_R) - (coef_term(g, K_V_G) + coef_term(b, K_V_B));
    on_chroma = !row_is_odd && !column_pos[0];
    w.luma = clip_byte(y_sum);
    w.chroma_valid = on_chroma;
    w.chroma_blue = on_chroma ? clip_byte(u_sum) : 8'd0;
    w.chroma_red = on_chroma ? clip_byte(v_sum) : 8'd0;
    // Widths above the counter range behave as the largest row; zero and one
    // end the row after every pixel.
    span = (width_setting > LINE_MAX) ? LINE_MAX : width_setting;
    if (int'(column_pos) + 1 >= span) begin
      column_pos = '0;
      row_is_odd = !row_is_odd;
    end else begin
      column_pos = column_pos + 12'd1;
    end
    return w;
  endfunction

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rgb_pair_t random_pixel(bit restart);
    rgb_pair_t px;
    px.first_red = pick_level();
    px.first_green = pick_level();
    px.first_blue = pick_level();
    px.second_red = pick_level();
    px.second_green = pick_level();
    px.second_blue = pick_level();
    px.frame_start = restart;
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. The current pixel stays on the bus until the block takes it; the
  // prediction is made at the same edge, so it sees exactly the accepted word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_pixels
    rgb_pair_t nxt;
    bit        busy;
    if (rst) begin
      pix_in_if.valid <= 1'b0;
    end else begin
      busy = pix_in_if.valid;
      if (pix_in_if.valid && pix_in_if.ready) begin
        yuv_expect_q.push_back(convert_pixel(pixel_on_offer));
        offer_pending = 1'b0;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_in_if.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          nxt = pixel_q.pop_front();
          pixel_on_offer = nxt;
          offer_pending = 1'b1;
          pix_in_if.first_red <= nxt.first_red;
          pix_in_if.first_green <= nxt.first_green;
          pix_in_if.first_blue <= nxt.first_blue;
          pix_in_if.second_red <= nxt.second_red;
          pix_in_if.second_green <= nxt.second_green;
          pix_in_if.second_blue <= nxt.second_blue;
          pix_in_if.frame_start <= nxt.frame_start;
          pix_in_if.valid <= 1'b1;
          if (sender_idle) send_gap = pick_gap();
        end else begin
          pix_in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Checks every output word against the oldest prediction and
  // drives ready, including the one long hold-off that backs up the block.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_yuv
    yuv_word_t exp_w;
    if (rst) begin
      pix_out_if.ready <= 1'b0;
    end else begin
      if (pix_out_if.valid && pix_out_if.ready) begin
        if (yuv_expect_q.size() == 0) begin
          $error("output word with none expected: luma %0d", pix_out_if.luma);
          error_count++;
        end else begin
          exp_w = yuv_expect_q.pop_front();
          words_checked++;
          if (exp_w.chroma_valid) chroma_words++;
          if (pix_out_if.luma !== exp_w.luma) begin
            $error("luma: expected %0d, actual %0d", exp_w.luma, pix_out_if.luma);
            error_count++;
          end
          if (pix_out_if.chroma_valid !== exp_w.chroma_valid) begin
            $error("chroma_valid: expected %0d, actual %0d",
                   exp_w.chroma_valid, pix_out_if.chroma_valid);
            error_count++;
          end
          if (pix_out_if.chroma_blue !== exp_w.chroma_blue) begin
            $error("chroma_blue: expected %0d, actual %0d",
                   exp_w.chroma_blue, pix_out_if.chroma_blue);
            error_count++;
          end
          if (pix_out_if.chroma_red !== exp_w.chroma_red) begin
            $error("chroma_red: expected %0d, actual %0d",
                   exp_w.chroma_red, pix_out_if.chroma_red);
            error_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_if.ready <= 1'b0;
      end else begin
        pix_out_if.ready <= 1'b1;
        if (receiver_idle && $urandom_range(0, 4) == 0) hold_left = pick_gap();
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_we || (pix_in_if.valid && pix_in_if.ready) ||
        (pix_out_if.valid && pix_out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d quiet cycles, %0d words outstanding",
                 idle_cycles, yuv_expect_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------

  // Returns once every queued pixel has been taken and every predicted word
  // has come back, then lets the pipeline settle so registers can be written.
  // This is also where the sender pauses until the block has run dry.
  task automatic wait_drained();
    while (pixel_q.size() != 0 || offer_pending || yuv_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; the enable stays high
  // across them so it is never dropped and raised in the same step.
  task automatic write_settings(logic [7:0] alpha, logic mode, logic [LINE_W-1:0] width);
    cfg_we <= 1'b1;
    cfg_index <= REG_BLEND_ALPHA;
    cfg_data <= CFG_DATA_W'(alpha);
    @(posedge clk);
    cfg_index <= REG_BLEND_MODE;
    cfg_data <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_LINE_WIDTH;
    cfg_data <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One stretch of random pixels under one group of settings. The first
  // pixel optionally restarts the frame; later ones restart it at a rate of
  // one in restart_odds (never when zero).
  task automatic run_phase(logic [7:0] alpha, logic mode, logic [LINE_W-1:0] width,
                           int count, bit restart, int restart_odds, bit idle);
    bit fs;
    wait_drained();
    write_settings(alpha, mode, width);
    setting_count++;
    sender_idle = idle;
    receiver_idle = idle;
    for (int i = 0; i < count; i++) begin
      if (i == 0) fs = restart;
      else fs = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
      pixel_q.push_back(random_pixel(fs));
    end
  endtask

  task automatic push_pixel(logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                            logic [7:0] r2, logic [7:0] g2, logic [7:0] b2, bit fs);
    rgb_pair_t px;
    px.first_red = r1;
    px.first_green = g1;
    px.first_blue = b1;
    px.second_red = r2;
    px.second_green = g2;
    px.second_blue = b2;
    px.frame_start = fs;
    pixel_q.push_back(px);
  endtask

  function automatic logic [7:0] pick_alpha();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    if (roll == 2) return 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  // Short rows most of the time so that row parity flips often.
  function automatic logic [LINE_W-1:0] pick_width();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return LINE_W'($urandom_range(0, 1));
    if (roll == 1) return LINE_W'($urandom_range(17, 64));
    if (roll == 2) return LINE_W'($urandom_range(LINE_MAX + 1, 8191));
    return LINE_W'($urandom_range(2, 16));
  endfunction

  initial begin : run_test
    // Every input is known from time zero.
    pix_in_if.valid = 1'b0;
    pix_in_if.first_red = '0;
    pix_in_if.first_green = '0;
    pix_in_if.first_blue = '0;
    pix_in_if.second_red = '0;
    pix_in_if.second_green = '0;
    pix_in_if.second_blue = '0;
    pix_in_if.frame_start = 1'b0;
    pix_out_if.ready = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the settings left by reset (half alpha, blend,
    // 1920 wide): component extremes, pure primaries, bit patterns, and a
    // frame restart in mid-row.
    push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 1'b0);
    push_pixel(8'h55, 8'h55, 8'h55, 8'haa, 8'haa, 8'haa, 1'b0);
    push_pixel(8'd16, 8'd128, 8'd240, 8'd235, 8'd16, 8'd128, 1'b1);
    push_pixel(8'd1, 8'd254, 8'd127, 8'd128, 8'd1, 8'd254, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127, 1'b0);

    // Alpha and mode extremes with the narrowest rows, including widths of
    // zero and one where every pixel closes its row.
    run_phase(8'd0, MODE_SCALE, LINE_W'(2), 150, 1'b1, 50, 1'b1);
    run_phase(8'd255, MODE_BLEND, LINE_W'(0), 100, 1'b0, 50, 1'b1);
    run_phase(8'd255, MODE_SCALE, LINE_W'(1), 100, 1'b1, 50, 1'b1);
    // Odd row length, with no idling on either side.
    run_phase(8'd0, MODE_BLEND, LINE_W'(7), 150, 1'b1, 50, 1'b0);

    // Shrink the row while the column counter is already past the new width:
    // the row must close after the next pixel without a frame restart.
    run_phase(pick_alpha(), MODE_BLEND, LINE_W'(20), 17, 1'b1, 0, 1'b1);
    run_phase(pick_alpha(), MODE_BLEND, LINE_W'(6), 150, 1'b0, 60, 1'b1);

    // Output side holds off for a long stretch while the driver keeps
    // offering words, so the block fills and stops taking input.
    run_phase(pick_alpha(), 1'($urandom_range(0, 1)), LINE_W'(4), 240, 1'b1, 40, 1'b0);
    hold_request = 1'b1;

    // Largest width register value: the row length is held at the counter
    // limit, so a long run without restarts stays on the first row.
    run_phase(pick_alpha(), 1'($urandom_range(0, 1)), LINE_W'(8191), 200,
              1'b1, 0, 1'b0);

    // Random settings and pixels.
    repeat (7) begin
      run_phase(pick_alpha(), 1'($urandom_range(0, 1)), pick_width(),
                $urandom_range(80, 120), 1'($urandom_range(0, 1)), 40,
                $urandom_range(0, 3) != 0);
    end

    wait_drained();
    $display("Checked %0d YUV words, %0d with chroma, over %0d register settings.",
             words_checked, chroma_words, setting_count);
    $display("Both alpha modes, alpha and width extremes, frame restarts and a long output stall.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rab_pkg.sv
hw/rtl/rab_channels.sv
hw/rtl/rab_ctrl.sv
hw/rtl/rab_datapath.sv
hw/rtl/rgb_alpha_blend_to_yuv420.sv
tb/sv/rgb_alpha_blend_to_yuv420_tb.sv
